// ===== hw/rtl/ecsm_pkg.sv =====
// ---------------------------------------------------------------------------
// ecsm_pkg: shared types and constants for the scalar multiply core
// Defaults, register indexes, state types and modular add/subtract helpers.
// ---------------------------------------------------------------------------
package ecsm_pkg;

	localparam int FIELD_BITS_DEF  = 31;
	localparam int SCALAR_BITS_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;

	// configuration register indexes
	localparam logic CFG_CURVE_A = 1'b0;
	localparam logic CFG_MODULUS = 1'b1;

	localparam logic [63:0] MODULUS_RST = 64'd2147483647;

	typedef enum logic [2:0] {
		F_IDLE,
		F_RED_X,
		F_RED_Y,
		F_RED_A,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LOOP,
		B_PADD,
		B_SQ,
		B_INV0,
		B_IDIV,
		B_IDW,
		B_IMW,
		B_S,
		B_X,
		B_XD,
		B_Y,
		B_WB,
		B_DONE
	} back_state_t;

	// status of an iterative arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	// (u + v) mod p for u, v < p
	function automatic logic [63:0] add_m(input logic [63:0] u, input logic [63:0] v,
			input logic [63:0] p);
		logic [63:0] s;
		s = u + v;
		return (s >= p) ? s - p : s;
	endfunction

	// (u - v) mod p for u, v < p
	function automatic logic [63:0] sub_m(input logic [63:0] u, input logic [63:0] v,
			input logic [63:0] p);
		return (u >= v) ? u - v : u + (p - v);
	endfunction

endpackage

// ===== hw/rtl/ecsm_if.sv =====
// ---------------------------------------------------------------------------
// ecsm channel interfaces
// Valid/ready channels for base points in and results out.
// ---------------------------------------------------------------------------
interface ecsm_in_if #(
	parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [FIELD_BITS-1:0]  point_x;
	logic [FIELD_BITS-1:0]  point_y;
	logic [SCALAR_BITS-1:0] scalar;

	modport source(output valid, point_x, point_y, scalar, input ready);
	modport sink(input valid, point_x, point_y, scalar, output ready);
endinterface

interface ecsm_out_if #(
	parameter int FIELD_BITS = ecsm_pkg::FIELD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] result_x;
	logic [FIELD_BITS-1:0] result_y;
	logic                  at_infinity;

	modport source(output valid, result_x, result_y, at_infinity, input ready);
	modport sink(input valid, result_x, result_y, at_infinity, output ready);
endinterface

// ===== hw/rtl/ecsm_div.sv =====
// ---------------------------------------------------------------------------
// ecsm_div: restoring divider
// One quotient bit per cycle; gives quotient and remainder.
// ---------------------------------------------------------------------------
module ecsm_div #(
	parameter int FIELD_BITS = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [FIELD_BITS-1:0]         num,
	input  logic [FIELD_BITS-1:0]         den,
	output logic [FIELD_BITS-1:0]         quo,
	output logic [FIELD_BITS-1:0]         rem,
	output ecsm_pkg::unit_status_t        stat
);
	import ecsm_pkg::*;

	localparam int CW = $clog2(FIELD_BITS + 1);

	logic [FIELD_BITS-1:0] n_q, d_q, quo_q, rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, done_q;
	logic [FIELD_BITS:0]   trial;
	logic                  fits;

	assign trial = {rem_q, n_q[FIELD_BITS-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(FIELD_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			quo_q <= {quo_q[FIELD_BITS-2:0], fits};
			rem_q <= fits ? FIELD_BITS'(trial - {1'b0, d_q}) : trial[FIELD_BITS-1:0];
		end
	end

	assign quo       = quo_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hw/rtl/ecsm_mulmod.sv =====
// ---------------------------------------------------------------------------
// ecsm_mulmod: bit-serial modular multiplier
// Double-and-add over the multiplier bits, MSB first, one bit per cycle.
// ---------------------------------------------------------------------------
module ecsm_mulmod #(
	parameter int FIELD_BITS = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [FIELD_BITS-1:0]  u,
	input  logic [FIELD_BITS-1:0]  v,
	input  logic [FIELD_BITS-1:0]  p,
	output logic [FIELD_BITS-1:0]  prod,
	output ecsm_pkg::unit_status_t stat
);
	import ecsm_pkg::*;

	localparam int CW = $clog2(FIELD_BITS + 1);

	logic [FIELD_BITS-1:0] u_q, v_q, p_q, r_q, r2, r3;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, done_q;

	assign r2 = FIELD_BITS'(add_m(64'(r_q), 64'(r_q), 64'(p_q)));
	assign r3 = v_q[FIELD_BITS-1] ? FIELD_BITS'(add_m(64'(r2), 64'(u_q), 64'(p_q))) : r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(FIELD_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= u;
			v_q <= v;
			p_q <= p;
			r_q <= '0;
		end else if (busy_q) begin
			v_q <= v_q << 1;
			r_q <= r3;
		end
	end

	assign prod      = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hw/rtl/ecsm_fifo.sv =====
// ---------------------------------------------------------------------------
// ecsm_fifo: job queue
// Small register queue between the front and back halves.
// ---------------------------------------------------------------------------
module ecsm_fifo #(
	parameter int DW    = 4 * ecsm_pkg::FIELD_BITS_DEF + ecsm_pkg::SCALAR_BITS_DEF,
	parameter int DEPTH = ecsm_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] dout,
	output logic          nonempty
);
	import ecsm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign dout     = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> nonempty)
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== hw/rtl/ecsm_front.sv =====
// ---------------------------------------------------------------------------
// ecsm_front: intake and operand reduction
// Accepts a point and reduces x, y, a mod p, or zeroes the scalar if p < 2.
// ---------------------------------------------------------------------------
module ecsm_front #(
	parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [FIELD_BITS-1:0]  in_x,
	input  logic [FIELD_BITS-1:0]  in_y,
	input  logic [SCALAR_BITS-1:0] in_k,
	input  logic [FIELD_BITS-1:0]  curve_a,
	input  logic [FIELD_BITS-1:0]  modulus,
	output logic                   push,
	input  logic                   full,
	output logic [FIELD_BITS-1:0]  job_x,
	output logic [FIELD_BITS-1:0]  job_y,
	output logic [FIELD_BITS-1:0]  job_a,
	output logic [FIELD_BITS-1:0]  job_p,
	output logic [SCALAR_BITS-1:0] job_k
);
	import ecsm_pkg::*;

	front_state_t state_q, state_d;
	logic [FIELD_BITS-1:0]  x_q, y_q, a_q, p_q;
	logic [SCALAR_BITS-1:0] k_q;
	logic                   div_start;
	logic [FIELD_BITS-1:0]  div_num, div_quo, div_rem;
	unit_status_t           div_stat;
	logic                   tiny;

	assign tiny = modulus < FIELD_BITS'(2);

	ecsm_div #(.FIELD_BITS(FIELD_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   ((state_q == F_IDLE) ? modulus : p_q),
		.quo   (div_quo),
		.rem   (div_rem),
		.stat  (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		push      = 1'b0;
		div_start = 1'b0;
		div_num   = in_x;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (tiny) begin
						state_d = F_PUSH;
					end else begin
						div_start = 1'b1;
						state_d   = F_RED_X;
					end
				end
			end
			F_RED_X: begin
				div_num = y_q;
				if (div_stat.done) begin
					div_start = 1'b1;
					state_d   = F_RED_Y;
				end
			end
			F_RED_Y: begin
				div_num = a_q;
				if (div_stat.done) begin
					div_start = 1'b1;
					state_d   = F_RED_A;
				end
			end
			F_RED_A: begin
				if (div_stat.done)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					x_q <= in_x;
					y_q <= in_y;
					a_q <= curve_a;
					p_q <= modulus;
					k_q <= tiny ? '0 : in_k;
				end
			end
			F_RED_X: if (div_stat.done) x_q <= div_rem;
			F_RED_Y: if (div_stat.done) y_q <= div_rem;
			F_RED_A: if (div_stat.done) a_q <= div_rem;
			default: ;
		endcase
	end

	assign job_x = x_q;
	assign job_y = y_q;
	assign job_a = a_q;
	assign job_p = p_q;
	assign job_k = k_q;

endmodule

// ===== hw/rtl/ecsm_back.sv =====
// ---------------------------------------------------------------------------
// ecsm_back: double-and-add sequencer
// Walks the scalar bits, runs affine point add/double on shared units.
// ---------------------------------------------------------------------------
module ecsm_back #(
	parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	output logic                   job_pop,
	input  logic [FIELD_BITS-1:0]  job_x,
	input  logic [FIELD_BITS-1:0]  job_y,
	input  logic [FIELD_BITS-1:0]  job_a,
	input  logic [FIELD_BITS-1:0]  job_p,
	input  logic [SCALAR_BITS-1:0] job_k,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [FIELD_BITS-1:0]  out_x,
	output logic [FIELD_BITS-1:0]  out_y,
	output logic                   out_inf
);
	import ecsm_pkg::*;

	localparam int W  = FIELD_BITS;
	localparam int CW = $clog2(SCALAR_BITS + 1);

	function automatic logic [W-1:0] fadd(input logic [W-1:0] u, input logic [W-1:0] v,
			input logic [W-1:0] p);
		return W'(add_m(64'(u), 64'(v), 64'(p)));
	endfunction

	function automatic logic [W-1:0] fsub(input logic [W-1:0] u, input logic [W-1:0] v,
			input logic [W-1:0] p);
		return W'(sub_m(64'(u), 64'(v), 64'(p)));
	endfunction

	back_state_t state_q, state_d;

	logic [W-1:0]           p_q, ca_q, acc_x_q, acc_y_q, bs_x_q, bs_y_q;
	logic [W-1:0]           num_q, r0_q, r1_q, t0_q, t1_q, rem_q, s_q, rx_q;
	logic [W-1:0]           res_x_q, res_y_q, out_x_q, out_y_q;
	logic [SCALAR_BITS-1:0] k_q;
	logic [CW-1:0]          cnt_q;
	logic                   phase_q, dbl_q, out_valid_q;

	logic [W-1:0] ax, ay, bx, by, inv, qm;
	logic         a_inf, b_inf, finished, emit;

	logic         mul_start, div_start;
	logic [W-1:0] mul_u, mul_v, mul_prod, div_quo, div_rem;
	unit_status_t mul_stat, div_stat;

	// doubling works on base+base, adding on acc+base
	assign ax    = dbl_q ? bs_x_q : acc_x_q;
	assign ay    = dbl_q ? bs_y_q : acc_y_q;
	assign bx    = bs_x_q;
	assign by    = bs_y_q;
	assign a_inf = (ax == '0) && (ay == '0);
	assign b_inf = (bx == '0) && (by == '0);
	assign inv   = (r0_q == W'(1)) ? t0_q : '0;
	assign qm    = (div_quo >= p_q) ? div_quo - p_q : div_quo;
	assign finished = (k_q == '0) || (cnt_q == CW'(SCALAR_BITS));
	assign emit  = (state_q == B_DONE) && (!out_valid_q || out_ready);

	ecsm_mulmod #(.FIELD_BITS(W)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.u     (mul_u),
		.v     (mul_v),
		.p     (p_q),
		.prod  (mul_prod),
		.stat  (mul_stat)
	);

	ecsm_div #(.FIELD_BITS(W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (r0_q),
		.den   (r1_q),
		.quo   (div_quo),
		.rem   (div_rem),
		.stat  (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		mul_start = 1'b0;
		mul_u     = ax;
		mul_v     = ax;
		div_start = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = B_LOOP;
				end
			end
			B_LOOP: begin
				if (finished)
					state_d = B_DONE;
				else if (phase_q || k_q[0])
					state_d = B_PADD;
			end
			B_PADD: begin
				if (a_inf || b_inf) begin
					state_d = B_WB;
				end else if (ax == bx) begin
					if (ay != by || ay == '0) begin
						state_d = B_WB;
					end else begin
						mul_start = 1'b1;
						state_d   = B_SQ;
					end
				end else begin
					state_d = B_INV0;
				end
			end
			B_SQ:   if (mul_stat.done) state_d = B_INV0;
			B_INV0: state_d = B_IDIV;
			B_IDIV: begin
				if (r1_q == '0) begin
					mul_start = 1'b1;
					mul_u     = num_q;
					mul_v     = inv;
					state_d   = B_S;
				end else begin
					div_start = 1'b1;
					state_d   = B_IDW;
				end
			end
			B_IDW: begin
				if (div_stat.done) begin
					mul_start = 1'b1;
					mul_u     = qm;
					mul_v     = t1_q;
					state_d   = B_IMW;
				end
			end
			B_IMW: if (mul_stat.done) state_d = B_IDIV;
			B_S: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_u     = mul_prod;
					mul_v     = mul_prod;
					state_d   = B_X;
				end
			end
			B_X:  if (mul_stat.done) state_d = B_XD;
			B_XD: begin
				mul_start = 1'b1;
				mul_u     = s_q;
				mul_v     = fsub(ax, rx_q, p_q);
				state_d   = B_Y;
			end
			B_Y:    if (mul_stat.done) state_d = B_WB;
			B_WB:   state_d = B_LOOP;
			B_DONE: if (emit) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					p_q     <= job_p;
					ca_q    <= job_a;
					bs_x_q  <= job_x;
					bs_y_q  <= job_y;
					k_q     <= job_k;
					acc_x_q <= '0;
					acc_y_q <= '0;
					cnt_q   <= '0;
					phase_q <= 1'b0;
					dbl_q   <= 1'b0;
				end
			end
			B_LOOP: begin
				if (!finished) begin
					if (phase_q)
						dbl_q <= 1'b1;
					else if (k_q[0])
						dbl_q <= 1'b0;
					else
						phase_q <= 1'b1;
				end
			end
			B_PADD: begin
				if (a_inf) begin
					res_x_q <= bx;
					res_y_q <= by;
				end else if (b_inf) begin
					res_x_q <= ax;
					res_y_q <= ay;
				end else if (ax == bx) begin
					res_x_q <= '0;
					res_y_q <= '0;
				end else begin
					num_q <= fsub(by, ay, p_q);
					r1_q  <= fsub(bx, ax, p_q);
				end
			end
			B_SQ: begin
				if (mul_stat.done) begin
					num_q <= fadd(fadd(fadd(mul_prod, mul_prod, p_q), mul_prod, p_q),
						ca_q, p_q);
					r1_q  <= fadd(ay, ay, p_q);
				end
			end
			B_INV0: begin
				r0_q <= p_q;
				t0_q <= '0;
				t1_q <= W'(1);
			end
			B_IDW: if (div_stat.done) rem_q <= div_rem;
			B_IMW: begin
				if (mul_stat.done) begin
					r0_q <= r1_q;
					r1_q <= rem_q;
					t0_q <= t1_q;
					t1_q <= fsub(t0_q, mul_prod, p_q);
				end
			end
			B_S: if (mul_stat.done) s_q <= mul_prod;
			B_X: if (mul_stat.done) rx_q <= fsub(fsub(mul_prod, ax, p_q), bx, p_q);
			B_Y: begin
				if (mul_stat.done) begin
					res_x_q <= rx_q;
					res_y_q <= fsub(mul_prod, ay, p_q);
				end
			end
			B_WB: begin
				if (dbl_q) begin
					bs_x_q  <= res_x_q;
					bs_y_q  <= res_y_q;
					k_q     <= k_q >> 1;
					cnt_q   <= cnt_q + 1'b1;
					phase_q <= 1'b0;
				end else begin
					acc_x_q <= res_x_q;
					acc_y_q <= res_y_q;
					phase_q <= 1'b1;
				end
			end
			B_DONE: begin
				if (emit) begin
					out_x_q <= acc_x_q;
					out_y_q <= acc_y_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_inf   = (out_x_q == '0) && (out_y_q == '0);

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy) else $error("multiplier restarted while busy");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (!div_stat.busy && r1_q != '0)) else $error("bad divider start");
	a_wb_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WB) |-> (res_x_q < p_q && res_y_q < p_q))
		else $error("point result not reduced");

endmodule

// ===== hw/rtl/ecc_scalar_multiply_core.sv =====
// ---------------------------------------------------------------------------
// ecc_scalar_multiply_core: affine elliptic-curve scalar multiplier
// Right-to-left double-and-add of k*P over a prime field, (0,0) = infinity.
// ---------------------------------------------------------------------------
// Work: front reduction is three divides, then per processed scalar bit one
//   doubling plus an add for each set bit; a point op costs 3 or 4 multiplies plus
//   one divide and one multiply per Euclid step of its inversion (tens of steps
//   at most).
// The back sequencer takes one job at a time and runs it on the shared bit-serial
//   multiplier and divider.
// Reset: curve_a clears to 0, modulus to 2^31-1, queue empties, no result pending.
module ecc_scalar_multiply_core #(
	parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [FIELD_BITS-1:0] cfg_data,
	ecsm_in_if.sink               in_ch,
	ecsm_out_if.source            out_ch
);
	import ecsm_pkg::*;

	localparam int JW = 4 * FIELD_BITS + SCALAR_BITS;

	// configuration registers, written only while the core is idle: a user duty, unchecked
	logic [FIELD_BITS-1:0] curve_a_q, modulus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_a_q <= '0;
			modulus_q <= FIELD_BITS'(MODULUS_RST);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CURVE_A: curve_a_q <= cfg_data;
				CFG_MODULUS: modulus_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front -> queue
	logic                   push, full;
	logic [FIELD_BITS-1:0]  f_x, f_y, f_a, f_p;
	logic [SCALAR_BITS-1:0] f_k;

	// queue -> back
	logic                   pop, q_valid;
	logic [JW-1:0]          q_data;
	logic [FIELD_BITS-1:0]  b_x, b_y, b_a, b_p;
	logic [SCALAR_BITS-1:0] b_k;

	// accept a beat, reduce its operands mod p, or zero the scalar if the modulus is below 2
	ecsm_front #(.FIELD_BITS(FIELD_BITS), .SCALAR_BITS(SCALAR_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_x    (in_ch.point_x),
		.in_y    (in_ch.point_y),
		.in_k    (in_ch.scalar),
		.curve_a (curve_a_q),
		.modulus (modulus_q),
		.push    (push),
		.full    (full),
		.job_x   (f_x),
		.job_y   (f_y),
		.job_a   (f_a),
		.job_p   (f_p),
		.job_k   (f_k)
	);

	// hold reduced jobs so intake runs ahead of the point arithmetic
	ecsm_fifo #(.DW(JW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.din     ({f_x, f_y, f_a, f_p, f_k}),
		.full    (full),
		.pop     (pop),
		.dout    (q_data),
		.nonempty(q_valid)
	);

	assign {b_x, b_y, b_a, b_p, b_k} = q_data;

	// advance double-and-add; the result register frees the sequencer
	// while a finished beat waits on the output
	ecsm_back #(.FIELD_BITS(FIELD_BITS), .SCALAR_BITS(SCALAR_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(q_valid),
		.job_pop  (pop),
		.job_x    (b_x),
		.job_y    (b_y),
		.job_a    (b_a),
		.job_p    (b_p),
		.job_k    (b_k),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_x    (out_ch.result_x),
		.out_y    (out_ch.result_y),
		.out_inf  (out_ch.at_infinity)
	);

endmodule
